FILE: rtl/core/digit_lz_copy_decoder_core_defines.svh
// shared assertion macros for the decoder core
`ifndef DIGIT_LZ_COPY_DECODER_CORE_DEFINES_SVH
`define DIGIT_LZ_COPY_DECODER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DLZD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DLZD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dlzd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dlzd_pkg;

    localparam int HISTORY_DEPTH = 9;
    localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int DIGIT_W = 4;
    localparam logic [DIGIT_W-1:0] RUN_LIMIT = 4'd9;

    typedef logic [HIST_AW-1:0] t_hist_addr;
    typedef logic [DIGIT_W-1:0] t_digit;

    typedef struct packed {
        logic   vld;
        t_digit digit;
        logic   last;
        logic   err;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/dlzd_copy_engine.sv
`timescale 1ns / 1ps
`default_nettype none

`include "digit_lz_copy_decoder_core_defines.svh"

module dlzd_copy_engine (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [3:0]            i_distance,
    input  wire logic [3:0]            i_copy_length,
    input  wire logic                  i_res_ready,
    output dlzd_pkg::t_result          o_res
);

    localparam int PW = dlzd_pkg::HIST_AW + 1;
    localparam int CW = dlzd_pkg::CNT_W;
    localparam logic [PW-1:0] DEPTH_P = PW'(dlzd_pkg::HISTORY_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(dlzd_pkg::HISTORY_DEPTH);
    localparam dlzd_pkg::t_hist_addr LAST_ADDR =
        dlzd_pkg::HIST_AW'(dlzd_pkg::HISTORY_DEPTH - 1);

    // history ring: newest digit sits just below the write pointer
    dlzd_pkg::t_digit r_mem [dlzd_pkg::HISTORY_DEPTH];
    dlzd_pkg::t_digit r_rdata;

    logic                 r_busy, n_busy;
    logic                 r_pend, n_pend;
    logic                 r_fwd, n_fwd;
    dlzd_pkg::t_digit     r_fwd_data;
    logic [3:0]           r_remain, n_remain;
    logic [3:0]           r_left, n_left;
    dlzd_pkg::t_hist_addr r_ra, n_ra;
    dlzd_pkg::t_hist_addr r_wp, n_wp;
    logic [CW-1:0]        r_count, n_count;

    logic                 in_acc, lit_hit, err_hit, cp_start, cp_out, iss, we;
    dlzd_pkg::t_digit     wdata, cp_digit;
    logic [3:0]           len_sat;
    logic [PW-1:0]        start_sum;
    dlzd_pkg::t_hist_addr start_ra;

    assign o_in_ready = !r_busy && i_res_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign lit_hit    = in_acc && (i_distance == 4'd0);
    assign err_hit    = in_acc && (i_distance != 4'd0) && (i_copy_length != 4'd0) &&
                        ({{CW{1'b0}}, i_distance} > {4'd0, r_count});
    assign cp_start   = in_acc && (i_distance != 4'd0) && (i_copy_length != 4'd0) &&
                        !err_hit;
    assign len_sat    = (i_copy_length > dlzd_pkg::RUN_LIMIT) ? dlzd_pkg::RUN_LIMIT
                                                              : i_copy_length;

    // distance never exceeds the fill count, so one subtract wraps the ring
    assign start_sum = {1'b0, r_wp} + DEPTH_P - PW'(i_distance);
    assign start_ra  = (start_sum >= DEPTH_P) ? dlzd_pkg::HIST_AW'(start_sum - DEPTH_P)
                                              : dlzd_pkg::HIST_AW'(start_sum);

    assign cp_out   = r_pend && i_res_ready;
    assign cp_digit = r_fwd ? r_fwd_data : r_rdata;
    assign iss      = r_busy && (r_remain != 4'd0) && (!r_pend || cp_out);
    assign we       = lit_hit || cp_out;
    assign wdata    = lit_hit ? i_copy_length : cp_digit;

    always_comb begin
        n_busy   = r_busy;
        n_pend   = r_pend;
        n_remain = r_remain;
        n_left   = r_left;
        n_ra     = r_ra;
        n_wp     = r_wp;
        n_count  = r_count;
        n_fwd    = r_fwd;

        if (cp_start) begin
            n_busy   = 1'b1;
            n_remain = len_sat;
            n_left   = len_sat;
            n_ra     = start_ra;
        end
        if (iss) begin
            n_remain = r_remain - 4'd1;
            n_ra     = (r_ra == LAST_ADDR) ? '0 : r_ra + 1'b1;
            // read of the slot being written this cycle takes the write data
            n_fwd    = we && (r_ra == r_wp);
        end
        if (iss) begin
            n_pend = 1'b1;
        end else if (cp_out) begin
            n_pend = 1'b0;
        end
        if (cp_out) begin
            n_left = r_left - 4'd1;
            if (r_left == 4'd1) begin
                n_busy = 1'b0;
            end
        end
        if (we) begin
            n_wp = (r_wp == LAST_ADDR) ? '0 : r_wp + 1'b1;
            if (r_count < DEPTH_C) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pend   <= 1'b0;
            r_fwd    <= 1'b0;
            r_remain <= '0;
            r_left   <= '0;
            r_ra     <= '0;
            r_wp     <= '0;
            r_count  <= '0;
        end else begin
            r_busy   <= n_busy;
            r_pend   <= n_pend;
            r_fwd    <= n_fwd;
            r_remain <= n_remain;
            r_left   <= n_left;
            r_ra     <= n_ra;
            r_wp     <= n_wp;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_wp] <= wdata;
        end
        if (iss) begin
            r_rdata <= r_mem[r_ra];
        end
        if (iss && n_fwd) begin
            r_fwd_data <= wdata;
        end
    end

    always_comb begin
        o_res.vld   = lit_hit || err_hit || cp_out;
        o_res.digit = cp_out ? cp_digit : (lit_hit ? i_copy_length : '0);
        o_res.last  = cp_out ? (r_left == 4'd1) : 1'b1;
        o_res.err   = err_hit;
    end

    `DLZD_ASSERT_IMP(a_pend_busy, r_pend, r_busy, "read pending while engine idle")
    `DLZD_ASSERT_IMP(a_count_max, 1'b1, r_count <= DEPTH_C, "fill count beyond depth")
    `DLZD_ASSERT_IMP(a_wp_range, 1'b1, r_wp <= LAST_ADDR, "write pointer out of range")
    `DLZD_ASSERT_NXT(a_last_done, cp_out && (r_left == 4'd1), !r_busy,
                     "engine still busy after final digit")
    `DLZD_ASSERT_IMP(a_issue_cnt, r_busy, r_remain <= r_left, "issued more reads than digits")

endmodule

`default_nettype wire

FILE: rtl/core/digit_lz_copy_decoder_core.sv
// a literal or error result shows on the output in the cycle after its beat; a copy
// registers its read address, reads the history ring, then loads one digit per cycle
// into the output register unless it stalls; the history ring read, write-back and
// forwarding loop sets that rate. The input waits during a copy of up to 9 digits.
// reset: synchronous, active low; clears fill count, pointers and output valid.
`timescale 1ns / 1ps
`default_nettype none

module digit_lz_copy_decoder_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // distance[3:0], copy_length[7:4]
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // digit[3:0], zero[7:4]
    output logic            o_m_tlast,
    output logic            o_m_tuser    // error[0]
);

    dlzd_pkg::t_result res;
    logic              can_load;
    logic              r_m_valid;
    dlzd_pkg::t_digit  r_m_digit;
    logic              r_m_last;
    logic              r_m_err;

    assign can_load = !r_m_valid || i_m_tready;

    dlzd_copy_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_tvalid),
        .o_in_ready    (o_s_tready),
        .i_distance    (i_s_tdata[3:0]),
        .i_copy_length (i_s_tdata[7:4]),
        .i_res_ready   (can_load),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (can_load) begin
            r_m_valid <= res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load && res.vld) begin
            r_m_digit <= res.digit;
            r_m_last  <= res.last;
            r_m_err   <= res.err;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {4'd0, r_m_digit};
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = r_m_err;

endmodule

`default_nettype wire

FILE: test/tb_digit_lz_copy_decoder_core.sv
`timescale 1ns / 1ps

module tb_digit_lz_copy_decoder_core;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 110;
    localparam int BURST_ITEMS  = 30;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    // receiver stall patterns
    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_COIN,
        SINK_QUARTER,
        SINK_PERIODIC
    } t_sink_mode;

    typedef struct packed {
        dlzd_pkg::t_digit digit;
        logic             last;
        logic             err;
    } t_decoded;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'd0;    // distance[3:0], copy_length[7:4]
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;           // digit[3:0], zero[7:4]
    logic       o_m_tlast;
    logic       o_m_tuser;           // error[0]

    digit_lz_copy_decoder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // predictor state: newest digit at index 0
    dlzd_pkg::t_digit hist_mem [dlzd_pkg::HISTORY_DEPTH];
    int unsigned      hist_fill = 0;
    t_decoded         pending_digits[$];

    int fail_count     = 0;
    int beats_sent     = 0;
    int digits_checked = 0;
    int literal_beats  = 0;
    int copy_beats     = 0;
    int far_beats      = 0;
    int empty_beats    = 0;
    int cycle_count    = 0;

    t_sink_mode sink_mode = SINK_ALWAYS;
    int hold_reqs   = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int sink_cyc    = 0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic void push_history(dlzd_pkg::t_digit d);
        for (int i = dlzd_pkg::HISTORY_DEPTH - 1; i > 0; i--) begin
            hist_mem[i] = hist_mem[i - 1];
        end
        hist_mem[0] = d;
        if (hist_fill < dlzd_pkg::HISTORY_DEPTH) begin
            hist_fill++;
        end
    endfunction

    function automatic void expect_beat(t_decoded res);
        pending_digits.insert(pending_digits.size(), res);
    endfunction

    // expected digits for one accepted pair
    function automatic void decode_pair(dlzd_pkg::t_digit back, dlzd_pkg::t_digit len);
        dlzd_pkg::t_digit run;
        dlzd_pkg::t_digit d;
        t_decoded         res;
        if (back == 0) begin
            push_history(len);
            res = '{digit: len, last: 1'b1, err: 1'b0};
            expect_beat(res);
            literal_beats++;
            return;
        end
        if (len == 0) begin
            empty_beats++;
            return;
        end
        if (back > hist_fill) begin
            res = '{digit: '0, last: 1'b1, err: 1'b1};
            expect_beat(res);
            far_beats++;
            return;
        end
        copy_beats++;
        run = (len > dlzd_pkg::RUN_LIMIT) ? dlzd_pkg::RUN_LIMIT : len;
        for (int k = 0; k < run; k++) begin
            d = hist_mem[(back - 1) % dlzd_pkg::HISTORY_DEPTH];
            push_history(d);
            res = '{digit: d, last: (k + 1 == run), err: 1'b0};
            expect_beat(res);
        end
    endfunction

    // pick a pair: mostly literals and reachable copies, some errors and empty copies
    function automatic void pick_pair(output dlzd_pkg::t_digit back,
                                      output dlzd_pkg::t_digit len);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35 || hist_fill == 0 && r < 80) begin
            back = '0;
            len  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9));
        end else if (r < 80) begin
            back = 4'($urandom_range(1, hist_fill));
            len  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(1, 9));
        end else if (r < 93) begin
            back = 4'($urandom_range(hist_fill + 1, 15));
            len  = 4'($urandom_range(1, 15));
        end else begin
            back = 4'($urandom_range(1, 15));
            len  = '0;
        end
    endfunction

    // leaves tvalid high after the beat; the caller lowers it for a gap
    task automatic send_pair(input dlzd_pkg::t_digit back, input dlzd_pkg::t_digit len);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {len, back};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        decode_pair(back, len);
        beats_sent++;
    endtask

    task automatic pause_source(input int n);
        i_s_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic test_empty_history;
        send_pair(4'd1, 4'd3);
        send_pair(4'd4, 4'd0);
        send_pair(4'd15, 4'd15);
        pause_source(2);
    endtask

    task automatic test_literals;
        send_pair(4'd0, 4'd0);
        send_pair(4'd2, 4'd5);     // reaches one past the single stored digit
        send_pair(4'd0, 4'd9);
        send_pair(4'd0, 4'd10);
        send_pair(4'd0, 4'd15);
        send_pair(4'd0, 4'd5);
        send_pair(4'd0, 4'd7);
        pause_source(3);
    endtask

    task automatic test_copies;
        send_pair(4'd1, 4'd1);
        send_pair(4'd2, 4'd9);     // overlaps its own output
        send_pair(4'd9, 4'd15);    // oldest entry, length saturates
        send_pair(4'd3, 4'd4);
        send_pair(4'd6, 4'd0);
        pause_source(1);
    endtask

    task automatic test_far_distance;
        send_pair(4'd10, 4'd1);
        send_pair(4'd15, 4'd9);
        send_pair(4'd12, 4'd0);
        send_pair(4'd9, 4'd2);
        pause_source(4);
    endtask

    task automatic test_random_stream;
        dlzd_pkg::t_digit back;
        dlzd_pkg::t_digit len;
        int               sent;
        int               burst;
        int               gap;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
                pick_pair(back, len);
                send_pair(back, len);
                sent++;
            end
            // about a third of the bursts run straight into the next one
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                pause_source(gap);
            end
        end
        pause_source(2);
    endtask

    task automatic test_output_backpressure;
        dlzd_pkg::t_digit back;
        dlzd_pkg::t_digit len;
        sink_mode <= SINK_ALWAYS;
        hold_reqs <= hold_reqs + 1;
        for (int i = 0; i < BURST_ITEMS; i++) begin
            pick_pair(back, len);
            send_pair(back, len);
        end
        pause_source(1);
    endtask

    // receiver: long hold-off on request, otherwise the selected stall pattern
    always @(posedge i_clk) begin
        sink_cyc <= sink_cyc + 1;
        if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (hold_served != hold_reqs) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            i_m_tready  <= 1'b0;
        end else begin
            case (sink_mode)
                SINK_ALWAYS:   i_m_tready <= 1'b1;
                SINK_COIN:     i_m_tready <= 1'($urandom_range(0, 1));
                SINK_QUARTER:  i_m_tready <= (sink_cyc % 4 == 0);
                SINK_PERIODIC: i_m_tready <= (sink_cyc % 7 < 4);
                default:       i_m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin : check_beats
        t_decoded want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_digits.size() == 0) begin
                $display("%0t: unexpected beat digit=%0d last=%0b error=%0b", $time,
                         o_m_tdata[3:0], o_m_tlast, o_m_tuser);
                fail_count++;
            end else begin
                want = pending_digits.pop_front();
                digits_checked++;
                if (o_m_tdata[3:0] !== want.digit) begin
                    $display("%0t: digit mismatch expected %0d actual %0d", $time,
                             want.digit, o_m_tdata[3:0]);
                    fail_count++;
                end
                if (o_m_tlast !== want.last) begin
                    $display("%0t: last mismatch expected %0b actual %0b", $time,
                             want.last, o_m_tlast);
                    fail_count++;
                end
                if (o_m_tuser !== want.err) begin
                    $display("%0t: error flag mismatch expected %0b actual %0b", $time,
                             want.err, o_m_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d digits outstanding", $time,
                     pending_digits.size());
            $display("tb_digit_lz_copy_decoder_core failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < dlzd_pkg::HISTORY_DEPTH; i++) begin
            hist_mem[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_history();
        test_literals();
        test_copies();
        test_far_distance();
        test_random_stream();
        test_output_backpressure();
        test_random_stream();

        i_s_tvalid <= 1'b0;
        sink_mode  <= SINK_ALWAYS;
        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d beats: %0d literals, %0d copies, %0d far distances,",
                 beats_sent, literal_beats, copy_beats, far_beats);
        $display("%0d empty copies, %0d output digits checked, one long output hold-off",
                 empty_beats, digits_checked);
        if (fail_count == 0) begin
            $display("tb_digit_lz_copy_decoder_core passed");
        end else begin
            $display("tb_digit_lz_copy_decoder_core failed");
        end
        $finish;
    end

endmodule
